// ===== rtl/vntc_pkg.sv =====
`default_nettype none

package vntc_pkg;

  // Fixed point: values in [0,1) carry FRAC fraction bits
  localparam int unsigned FRAC       = 24;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned FREQ_W     = 20;
  localparam int unsigned PROD_W     = COORD_W + FREQ_W;
  localparam int unsigned Q_W        = PROD_W - FRAC;
  localparam int unsigned CELL_W     = Q_W + 1;
  localparam int unsigned HASH_W     = 64;
  localparam int unsigned HALF_W     = HASH_W / 2;
  localparam int unsigned SMOOTH_W   = FRAC + 2;
  localparam int unsigned HEIGHT_W   = 6;
  localparam int unsigned Y_W        = 6;
  localparam int unsigned SCALE_BITS = 4;
  localparam int unsigned OCT_LAT    = 13;

  localparam int unsigned MIX_SH1 = 30;
  localparam int unsigned MIX_SH2 = 27;
  localparam int unsigned MIX_SH3 = 31;

  localparam logic [HASH_W-1:0] MIX_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [HASH_W-1:0] MIX_B  = 64'h94d049bb133111eb;
  localparam logic [HASH_W-1:0] GOLDEN = 64'h9e3779b97f4a7c15;

  localparam logic [63:0] FX_ONE = 64'd1 << FRAC;
  localparam logic [FREQ_W-1:0] FREQ_LOW  = FREQ_W'((64'd15 * FX_ONE + 64'd500) / 64'd1000);
  localparam logic [FREQ_W-1:0] FREQ_HIGH = FREQ_W'((64'd60 * FX_ONE + 64'd500) / 64'd1000);
  localparam logic [SMOOTH_W-1:0] SMOOTH_THREE = SMOOTH_W'(64'd3 * FX_ONE);

  localparam logic [HEIGHT_W-1:0] HEIGHT_BASE = 6'd24;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX  = HEIGHT_BASE + HEIGHT_W'((1 << SCALE_BITS) - 1);
  localparam logic [HEIGHT_W:0]   DIRT_DEPTH  = 7'd4;

  typedef enum logic [1:0] {
    CLASS_AIR   = 2'd0,
    CLASS_GRASS = 2'd1,
    CLASS_DIRT  = 2'd2,
    CLASS_STONE = 2'd3
  } class_e;

  // Partial products of a 64 x 64 multiply kept modulo 2^64
  typedef struct packed {
    logic [HASH_W-1:0] p0;
    logic [HALF_W-1:0] p1;
    logic [HALF_W-1:0] p2;
  } mul_parts_t;

  function automatic mul_parts_t mul_parts(input logic [HASH_W-1:0] a,
                                           input logic [HASH_W-1:0] b);
    mul_parts_t p;
    p.p0 = {{HALF_W{1'b0}}, a[HALF_W-1:0]} * {{HALF_W{1'b0}}, b[HALF_W-1:0]};
    p.p1 = a[HALF_W-1:0] * b[HASH_W-1:HALF_W];
    p.p2 = a[HASH_W-1:HALF_W] * b[HALF_W-1:0];
    return p;
  endfunction

  function automatic logic [HASH_W-1:0] mul_sum(input mul_parts_t p);
    logic [HALF_W-1:0] mid;
    mid = p.p1 + p.p2;
    return p.p0 + {mid, {HALF_W{1'b0}}};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vntc_axis.sv =====
`default_nettype none

// One axis of one octave: split coord*freq into cell and fraction, smooth the
// fraction, and form cell*mult and (cell+1)*mult modulo 2^64. Five stages.
module vntc_axis (
  input  wire                                 clk_i,
  input  wire                                 en_i,
  input  wire [vntc_pkg::COORD_W-1:0]         coord_i,
  input  wire [vntc_pkg::FREQ_W-1:0]          freq_i,
  input  wire [vntc_pkg::HASH_W-1:0]          mult_i,
  output logic [vntc_pkg::HASH_W-1:0]         prod_o,
  output logic [vntc_pkg::HASH_W-1:0]         prod_next_o,
  output logic [vntc_pkg::FRAC-1:0]           weight_o
);

  localparam int unsigned FRAC     = vntc_pkg::FRAC;
  localparam int unsigned COORD_W  = vntc_pkg::COORD_W;
  localparam int unsigned PROD_W   = vntc_pkg::PROD_W;
  localparam int unsigned Q_W      = vntc_pkg::Q_W;
  localparam int unsigned CELL_W   = vntc_pkg::CELL_W;
  localparam int unsigned HASH_W   = vntc_pkg::HASH_W;
  localparam int unsigned SMOOTH_W = vntc_pkg::SMOOTH_W;

  // stage 1: magnitude times frequency
  logic                 neg_d;
  logic [COORD_W-1:0]   mag_d;
  logic                 neg_q;
  logic [PROD_W-1:0]    prod_q;

  assign neg_d = coord_i[COORD_W-1];
  assign mag_d = neg_d ? (COORD_W'(0) - coord_i) : coord_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q  <= neg_d;
      prod_q <= {{(PROD_W-COORD_W){1'b0}}, mag_d} *
                {{(PROD_W-vntc_pkg::FREQ_W){1'b0}}, freq_i};
    end
  end

  // stage 2: floor cell and fraction
  logic [Q_W-1:0]    q_w;
  logic [FRAC-1:0]   r_w;
  logic [CELL_W-1:0] qx_w;
  logic [CELL_W-1:0] cell_d;
  logic [FRAC-1:0]   frac_d;
  logic [CELL_W-1:0] cell_q;
  logic [FRAC-1:0]   frac_q;

  assign q_w  = prod_q[PROD_W-1:FRAC];
  assign r_w  = prod_q[FRAC-1:0];
  assign qx_w = {1'b0, q_w};

  always_comb begin
    priority if (!neg_q) begin
      cell_d = qx_w;
    end else if (r_w == '0) begin
      cell_d = CELL_W'(0) - qx_w;
    end else begin
      cell_d = ~qx_w;
    end
    frac_d = neg_q ? (FRAC'(0) - r_w) : r_w;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
      frac_q <= frac_d;
    end
  end

  // stage 3: cell partial products, t squared
  logic [HASH_W-1:0]        cell_ext;
  logic [2*FRAC-1:0]        sq_w;
  vntc_pkg::mul_parts_t     parts_q;
  logic [FRAC-1:0]          t_q;
  logic [FRAC-1:0]          t2_q;

  assign cell_ext = {{(HASH_W-CELL_W){cell_q[CELL_W-1]}}, cell_q};
  assign sq_w     = {{FRAC{1'b0}}, frac_q} * {{FRAC{1'b0}}, frac_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      parts_q <= vntc_pkg::mul_parts(cell_ext, mult_i);
      t_q     <= frac_q;
      t2_q    <= sq_w[2*FRAC-1:FRAC];
    end
  end

  // stage 4: sum partials, finish smoothstep t^2 * (3 - 2t)
  logic [SMOOTH_W-1:0]      fac_w;
  logic [FRAC+SMOOTH_W-1:0] sp_w;
  logic [HASH_W-1:0]        base_q;
  logic [FRAC-1:0]          s_q;

  assign fac_w = vntc_pkg::SMOOTH_THREE - {1'b0, t_q, 1'b0};
  assign sp_w  = {{SMOOTH_W{1'b0}}, t2_q} * {{FRAC{1'b0}}, fac_w};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q <= vntc_pkg::mul_sum(parts_q);
      s_q    <= sp_w[2*FRAC-1:FRAC];
    end
  end

  // stage 5: neighbor cell product is one constant step further
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o      <= base_q;
      prod_next_o <= base_q + mult_i;
      weight_o    <= s_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vntc_hash.sv =====
`default_nettype none

// Lattice corner hash: mix64(seed ^ a ^ b), top FRAC bits. Four stages.
module vntc_hash (
  input  wire                           clk_i,
  input  wire                           en_i,
  input  wire [vntc_pkg::HASH_W-1:0]    seed_i,
  input  wire [vntc_pkg::HASH_W-1:0]    a_i,
  input  wire [vntc_pkg::HASH_W-1:0]    b_i,
  output logic [vntc_pkg::FRAC-1:0]     corner_o
);

  localparam int unsigned HASH_W = vntc_pkg::HASH_W;
  localparam int unsigned FRAC   = vntc_pkg::FRAC;

  logic [HASH_W-1:0]    x_w;
  logic [HASH_W-1:0]    x1_w;
  logic [HASH_W-1:0]    y2_w;
  logic [HASH_W-1:0]    fin_w;
  vntc_pkg::mul_parts_t parts_a_q;
  vntc_pkg::mul_parts_t parts_b_q;
  logic [HASH_W-1:0]    y_q;
  logic [HASH_W-1:0]    z_q;

  assign x_w   = seed_i ^ a_i ^ b_i;
  assign x1_w  = x_w ^ (x_w >> vntc_pkg::MIX_SH1);
  assign y2_w  = y_q ^ (y_q >> vntc_pkg::MIX_SH2);
  assign fin_w = z_q ^ (z_q >> vntc_pkg::MIX_SH3);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      parts_a_q <= vntc_pkg::mul_parts(x1_w, vntc_pkg::MIX_A);
      y_q       <= vntc_pkg::mul_sum(parts_a_q);
      parts_b_q <= vntc_pkg::mul_parts(y2_w, vntc_pkg::MIX_B);
      z_q       <= vntc_pkg::mul_sum(parts_b_q);
    end
  end

  assign corner_o = fin_w[HASH_W-1 -: FRAC];

endmodule

`default_nettype wire

// ===== rtl/vntc_octave.sv =====
`default_nettype none

// One octave of 2D value noise at frequency freq_i, OCT_LAT pipeline stages deep.
module vntc_octave (
  input  wire                           clk_i,
  input  wire                           en_i,
  input  wire [vntc_pkg::FREQ_W-1:0]    freq_i,
  input  wire [vntc_pkg::HASH_W-1:0]    seed_i,
  input  wire [vntc_pkg::COORD_W-1:0]   world_x_i,
  input  wire [vntc_pkg::COORD_W-1:0]   world_z_i,
  output logic [vntc_pkg::FRAC-1:0]     value_o
);

  localparam int unsigned FRAC   = vntc_pkg::FRAC;
  localparam int unsigned HASH_W = vntc_pkg::HASH_W;
  localparam int unsigned TX_DLY = 4;
  localparam int unsigned TZ_DLY = 6;

  typedef struct packed {
    logic            ge;
    logic [FRAC-1:0] base;
    logic [FRAC-1:0] step;
  } lerp_t;

  function automatic lerp_t lerp_mul(input logic [FRAC-1:0] a, input logic [FRAC-1:0] b,
                                     input logic [FRAC-1:0] w);
    lerp_t             l;
    logic [FRAC-1:0]   d;
    logic [2*FRAC-1:0] p;
    l.ge   = (b >= a);
    d      = l.ge ? (b - a) : (a - b);
    p      = {{FRAC{1'b0}}, d} * {{FRAC{1'b0}}, w};
    l.base = a;
    l.step = p[2*FRAC-1:FRAC];
    return l;
  endfunction

  function automatic logic [FRAC-1:0] lerp_add(input lerp_t l);
    return l.ge ? (l.base + l.step) : (l.base - l.step);
  endfunction

  logic [HASH_W-1:0] px, px1, pz, pz1;
  logic [FRAC-1:0]   tx, tz;
  logic [FRAC-1:0]   c00, c10, c01, c11;

  vntc_axis u_axis_x (
    .clk_i       (clk_i),
    .en_i        (en_i),
    .coord_i     (world_x_i),
    .freq_i      (freq_i),
    .mult_i      (vntc_pkg::GOLDEN),
    .prod_o      (px),
    .prod_next_o (px1),
    .weight_o    (tx)
  );

  vntc_axis u_axis_z (
    .clk_i       (clk_i),
    .en_i        (en_i),
    .coord_i     (world_z_i),
    .freq_i      (freq_i),
    .mult_i      (vntc_pkg::MIX_A),
    .prod_o      (pz),
    .prod_next_o (pz1),
    .weight_o    (tz)
  );

  vntc_hash u_hash_00 (.clk_i(clk_i), .en_i(en_i), .seed_i(seed_i),
                       .a_i(px),  .b_i(pz),  .corner_o(c00));
  vntc_hash u_hash_10 (.clk_i(clk_i), .en_i(en_i), .seed_i(seed_i),
                       .a_i(px1), .b_i(pz),  .corner_o(c10));
  vntc_hash u_hash_01 (.clk_i(clk_i), .en_i(en_i), .seed_i(seed_i),
                       .a_i(px),  .b_i(pz1), .corner_o(c01));
  vntc_hash u_hash_11 (.clk_i(clk_i), .en_i(en_i), .seed_i(seed_i),
                       .a_i(px1), .b_i(pz1), .corner_o(c11));

  // Hold weights alongside the hash pipeline
  logic [FRAC-1:0] tx_q [TX_DLY];
  logic [FRAC-1:0] tz_q [TZ_DLY];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tx_q[0] <= tx;
      for (int i = 1; i < TX_DLY; i++) begin
        tx_q[i] <= tx_q[i-1];
      end
      tz_q[0] <= tz;
      for (int i = 1; i < TZ_DLY; i++) begin
        tz_q[i] <= tz_q[i-1];
      end
    end
  end

  lerp_t           top_l_q, bot_l_q, val_l_q;
  logic [FRAC-1:0] top_q, bot_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      top_l_q <= lerp_mul(c00, c10, tx_q[TX_DLY-1]);
      bot_l_q <= lerp_mul(c01, c11, tx_q[TX_DLY-1]);
      top_q   <= lerp_add(top_l_q);
      bot_q   <= lerp_add(bot_l_q);
      val_l_q <= lerp_mul(top_q, bot_q, tz_q[TZ_DLY-1]);
      value_o <= lerp_add(val_l_q);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/value_noise_terrain_classifier.sv =====
`default_nettype none

// Heightmap terrain classifier. Each input beat carries one voxel coordinate;
// the block samples two octaves of 2D value noise at (world_x, world_z), with
// lattice frequencies 0.015 and 0.060 (24 fraction bits, rounded) weighted 3/4
// and 1/4, turns the blend into a column height 24..39 and compares world_y
// against it: above is air, equal is grass, down to four below is dirt, deeper
// is stone. Each corner value is the top 24 bits of a 64-bit mix hash of
// noise_seed and the corner coordinates. The pipeline is fully registered
// through its 64-bit multiplies (split into 32-bit partial products), so it
// takes one beat per cycle while the skid entry is free; a beat goes through
// the input, octave, height and output registers in turn. A one-entry skid
// stage behind the output register absorbs the beat still in flight when
// out_stall_i rises, so an input beat is taken in the cycle a result starts
// waiting; in_stall_o rises only while the skid entry is full. noise_seed has
// its own write channel, always ready; write it only while no beat is in flight.
module value_noise_terrain_classifier (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire signed [vntc_pkg::COORD_W-1:0] world_x_i,
  input  wire signed [vntc_pkg::COORD_W-1:0] world_y_i,
  input  wire signed [vntc_pkg::COORD_W-1:0] world_z_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [1:0]                       block_class_o,
  output logic [vntc_pkg::HEIGHT_W-1:0]    surface_height_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [vntc_pkg::HASH_W-1:0]       noise_seed_i
);

  localparam int unsigned FRAC      = vntc_pkg::FRAC;
  localparam int unsigned COORD_W   = vntc_pkg::COORD_W;
  localparam int unsigned HASH_W    = vntc_pkg::HASH_W;
  localparam int unsigned HEIGHT_W  = vntc_pkg::HEIGHT_W;
  localparam int unsigned Y_W       = vntc_pkg::Y_W;
  localparam int unsigned SUM_W     = FRAC + 2;
  localparam int unsigned PIPE_LAST = vntc_pkg::OCT_LAT + 1;

  // Seed register: take every write beat
  logic [HASH_W-1:0] seed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      seed_q <= noise_seed_i;
    end
  end

  // Whole pipeline advances while the skid entry is free
  logic adv;
  logic skid_v_q;

  assign adv        = !skid_v_q;
  assign in_stall_o = skid_v_q;

  logic [PIPE_LAST:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[PIPE_LAST-1:0], in_valid_i};
    end
  end

  // Clamp height comparison operand: heights live in 24..39, so anything
  // below zero is stone and anything above 63 is air either way.
  logic [Y_W-1:0] y_clamp_d;

  always_comb begin
    priority if (world_y_i[COORD_W-1]) begin
      y_clamp_d = '0;
    end else if (|world_y_i[COORD_W-2:Y_W]) begin
      y_clamp_d = '1;
    end else begin
      y_clamp_d = world_y_i[Y_W-1:0];
    end
  end

  logic [COORD_W-1:0] x_q, z_q;
  logic [Y_W-1:0]     y_q [PIPE_LAST+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q    <= world_x_i;
      z_q    <= world_z_i;
      y_q[0] <= y_clamp_d;
      for (int i = 1; i <= PIPE_LAST; i++) begin
        y_q[i] <= y_q[i-1];
      end
    end
  end

  // Two octaves side by side
  logic [FRAC-1:0] low_v, high_v;

  vntc_octave u_oct_low (
    .clk_i     (clk_i),
    .en_i      (adv),
    .freq_i    (vntc_pkg::FREQ_LOW),
    .seed_i    (seed_q),
    .world_x_i (x_q),
    .world_z_i (z_q),
    .value_o   (low_v)
  );

  vntc_octave u_oct_high (
    .clk_i     (clk_i),
    .en_i      (adv),
    .freq_i    (vntc_pkg::FREQ_HIGH),
    .seed_i    (seed_q),
    .world_x_i (x_q),
    .world_z_i (z_q),
    .value_o   (high_v)
  );

  // combined = (3*low + high) / 4, height = 24 + combined * 16 (integer part)
  logic [SUM_W-1:0]    sum_d;
  logic [FRAC-1:0]     combined_d;
  logic [HEIGHT_W-1:0] height_d;
  logic [HEIGHT_W-1:0] height_q;

  assign sum_d      = {2'b00, low_v} + {1'b0, low_v, 1'b0} + {2'b00, high_v};
  assign combined_d = sum_d[SUM_W-1:2];
  assign height_d   = vntc_pkg::HEIGHT_BASE +
                      HEIGHT_W'(combined_d[FRAC-1 -: vntc_pkg::SCALE_BITS]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      height_q <= height_d;
    end
  end

  // Classify against the column height
  vntc_pkg::class_e cls_d;
  logic [Y_W-1:0]   y_last;

  assign y_last = y_q[PIPE_LAST];

  always_comb begin
    priority if (y_last > height_q) begin
      cls_d = vntc_pkg::CLASS_AIR;
    end else if (y_last == height_q) begin
      cls_d = vntc_pkg::CLASS_GRASS;
    end else if (({1'b0, y_last} + vntc_pkg::DIRT_DEPTH) >= {1'b0, height_q}) begin
      cls_d = vntc_pkg::CLASS_DIRT;
    end else begin
      cls_d = vntc_pkg::CLASS_STONE;
    end
  end

  // Output register plus skid entry
  logic                 push;
  logic                 out_take;
  logic                 out_v_q;
  vntc_pkg::class_e     out_cls_q, skid_cls_q;
  logic [HEIGHT_W-1:0]  out_h_q, skid_h_q;

  assign push     = adv && v_q[PIPE_LAST];
  assign out_take = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      priority if (skid_v_q) begin
        // drain skid into the output register
        if (out_take) begin
          skid_v_q <= 1'b0;
        end
      end else if (!out_v_q || out_take) begin
        out_v_q <= push;
      end else begin
        if (push) begin
          skid_v_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (skid_v_q) begin
      if (out_take) begin
        out_cls_q <= skid_cls_q;
        out_h_q   <= skid_h_q;
      end
    end else if (!out_v_q || out_take) begin
      if (push) begin
        out_cls_q <= cls_d;
        out_h_q   <= height_q;
      end
    end else begin
      if (push) begin
        skid_cls_q <= cls_d;
        skid_h_q   <= height_q;
      end
    end
  end

  assign out_valid_o      = out_v_q;
  assign block_class_o    = out_cls_q;
  assign surface_height_o = out_h_q;

endmodule

`default_nettype wire

// ===== rtl/vntc_checker.sv =====
`default_nettype none

module vntc_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            in_valid_i,
  input wire                            in_stall_i,
  input wire                            out_valid_i,
  input wire                            out_stall_i,
  input wire [1:0]                      block_class_i,
  input wire [vntc_pkg::HEIGHT_W-1:0]   surface_height_i
);

  localparam int unsigned CNT_W = $clog2(vntc_pkg::OCT_LAT + 6);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] cnt_d, cnt_q;

  assign in_acc  = in_valid_i && !in_stall_i;
  assign out_acc = out_valid_i && !out_stall_i;
  assign cnt_d   = cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=>
      out_valid_i && $stable(block_class_i) && $stable(surface_height_i))
    else $error("stalled output beat changed");

  a_height_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      surface_height_i >= vntc_pkg::HEIGHT_BASE && surface_height_i <= vntc_pkg::HEIGHT_MAX)
    else $error("surface height out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> out_valid_i)
    else $error("input stalled with no output beat waiting");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> cnt_q != '0)
    else $error("output beat with no input beat outstanding");

endmodule

bind value_noise_terrain_classifier vntc_checker u_vntc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_i       (in_stall_o),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .block_class_i    (block_class_o),
  .surface_height_i (surface_height_o)
);

`default_nettype wire
